/* src/bcd_hms_game_clock_core_assert.svh */
// Assertion macros shared by the game clock modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef BCD_HMS_GAME_CLOCK_CORE_ASSERT_SVH
`define BCD_HMS_GAME_CLOCK_CORE_ASSERT_SVH

// Same-cycle implication.
`define BHGC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BHGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bhgc_pkg.sv */
package bhgc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  // Index 0 is the hour tens digit, index 5 the second ones digit.
  typedef logic [5:0][3:0] digits_t;

  typedef struct packed {
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

  typedef struct packed {
    logic    passed;
    digits_t digits;
    logic    timed_out;
    logic    running;
  } result_t;

  localparam logic [18:0] SECS_MAX        = 19'd359999;
  localparam logic [31:0] JIFFIES_PER_SEC = 32'd60;
  localparam logic [5:0]  SAVED_RESET     = 6'd60;
  localparam logic [4:0]  DRIFT_PERIOD    = 5'd20;
  localparam logic [31:0] DRIFT_ADD       = 32'd3;

  // The concatenation lists index 5 first, down to index 0 last.
  localparam digits_t DIGIT_TOP = {4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd9};

  // Reciprocal constants for the limit conversion; both estimates may come
  // out one low and are corrected by a single compare and subtract.
  localparam logic [37:0] RECIP_3600 = 38'd37282;
  localparam logic [39:0] RECIP_60   = 40'd559240;

  function automatic logic [3:0] dec_tens(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] dec_ones(input logic [6:0] v);
    logic [6:0] t;
    t = 7'(dec_tens(v)) * 7'd10;
    return 4'(v - t);
  endfunction

endpackage

/* src/bhgc_limit_conv.sv */
module bhgc_limit_conv (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [18:0] cfg_wdata,
  output logic [18:0] limit,
  output bhgc_pkg::hms_t limit_hms
);
  import bhgc_pkg::*;

  logic [18:0] conv_n;
  logic [7:0]  hour_est;
  logic [13:0] min_est;

  logic [37:0] hour_prod;
  logic [39:0] min_prod;
  logic [19:0] hour_rem;
  logic [19:0] min_rem;
  logic        hour_fix;
  logic        min_fix;
  logic [7:0]  hours_c;
  logic [13:0] total_min;
  logic [13:0] min_in_hour;
  logic [5:0]  secs_c;

  assign hour_prod = 38'(cfg_wdata) * RECIP_3600;
  assign min_prod  = 40'(cfg_wdata) * RECIP_60;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // First stage: reciprocal estimates of hours and whole minutes.
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      conv_n   <= cfg_wdata;
      hour_est <= hour_prod[34:27];
      min_est  <= min_prod[38:25];
    end
  end

  assign hour_rem    = 20'(conv_n) - 20'(hour_est) * 20'd3600;
  assign hour_fix    = hour_rem >= 20'd3600;
  assign hours_c     = hour_est + 8'(hour_fix);
  assign min_rem     = 20'(conv_n) - 20'(min_est) * 20'd60;
  assign min_fix     = min_rem >= 20'd60;
  assign total_min   = min_est + 14'(min_fix);
  assign secs_c      = min_fix ? 6'(min_rem - 20'd60) : min_rem[5:0];
  assign min_in_hour = total_min - 14'(hours_c) * 14'd60;

  // Second stage: hours, minutes within the hour and seconds.
  always_ff @(posedge clk) begin
    limit_hms.hours   <= hours_c;
    limit_hms.minutes <= min_in_hour[5:0];
    limit_hms.seconds <= secs_c;
  end

endmodule

/* src/bhgc_engine.sv */
`include "bcd_hms_game_clock_core_assert.svh"

module bhgc_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  bhgc_pkg::cmd_t cmd,
  input  logic [31:0]    now,
  input  logic [18:0]    limit,
  input  bhgc_pkg::hms_t limit_hms,
  output bhgc_pkg::result_t res
);
  import bhgc_pkg::*;

  logic        run;
  logic        tmo;
  logic        down;
  logic [18:0] elapsed;
  logic [5:0]  saved;
  logic [31:0] deadline;
  logic [4:0]  drift;
  digits_t     digits;

  logic        run_next;
  logic        tmo_next;
  logic        down_next;
  logic [18:0] elapsed_next;
  logic [5:0]  saved_next;
  logic [31:0] deadline_next;
  logic [4:0]  drift_next;
  digits_t     digits_next;
  logic        passed;

  logic [31:0] dl_sec;
  logic [31:0] lag_now;
  logic [31:0] lag_next;
  logic [31:0] lead;
  logic [4:0]  drift_dec;
  logic [18:0] elapsed_inc;
  logic [5:0]  at_top;
  logic [5:0]  at_zero;
  logic [5:0]  carry;
  digits_t     digits_step;
  digits_t     digits_limit;
  logic [6:0]  hour_mod;

  assign dl_sec      = deadline + JIFFIES_PER_SEC;
  assign lag_now     = now - deadline;
  assign lag_next    = now - dl_sec;
  assign lead        = deadline - now;
  assign drift_dec   = drift - 5'd1;
  assign elapsed_inc = (elapsed < SECS_MAX) ? elapsed + 19'd1 : elapsed;

  // BCD ripple: a digit steps when every digit below it wraps.
  assign carry[5] = 1'b1;
  for (genvar i = 0; i < 6; i++) begin : g_digit
    assign at_top[i]  = digits[i] == DIGIT_TOP[i];
    assign at_zero[i] = digits[i] == 4'd0;
    if (i < 5) begin : g_carry
      assign carry[i] = carry[i+1] && (down ? at_zero[i+1] : at_top[i+1]);
    end
    always_comb begin
      if (!carry[i]) begin
        digits_step[i] = digits[i];
      end else if (down) begin
        digits_step[i] = at_zero[i] ? DIGIT_TOP[i] : digits[i] - 4'd1;
      end else begin
        digits_step[i] = at_top[i] ? 4'd0 : digits[i] + 4'd1;
      end
    end
  end

  assign hour_mod = (limit_hms.hours >= 8'd100) ? 7'(limit_hms.hours - 8'd100)
                                                : limit_hms.hours[6:0];
  assign digits_limit[0] = dec_tens(hour_mod);
  assign digits_limit[1] = dec_ones(hour_mod);
  assign digits_limit[2] = dec_tens(7'(limit_hms.minutes));
  assign digits_limit[3] = dec_ones(7'(limit_hms.minutes));
  assign digits_limit[4] = dec_tens(7'(limit_hms.seconds));
  assign digits_limit[5] = dec_ones(7'(limit_hms.seconds));

  always_comb begin
    run_next      = run;
    tmo_next      = tmo;
    down_next     = down;
    elapsed_next  = elapsed;
    saved_next    = saved;
    deadline_next = deadline;
    drift_next    = drift;
    digits_next   = digits;
    passed        = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        if (run && !tmo && !lag_now[31]) begin
          if (!lag_next[31]) begin
            // Fell a whole second behind: resynchronize to the time base.
            deadline_next = now + JIFFIES_PER_SEC;
          end else if (drift_dec == 5'd0) begin
            deadline_next = dl_sec + DRIFT_ADD;
            drift_next    = DRIFT_PERIOD;
          end else begin
            deadline_next = dl_sec;
            drift_next    = drift_dec;
          end
          elapsed_next = elapsed_inc;
          digits_next  = digits_step;
          if (down && elapsed_inc >= limit) begin
            tmo_next = 1'b1;
            run_next = 1'b0;
          end
          passed = 1'b1;
        end
      end
      CMD_START: begin
        if (!run && !tmo) begin
          deadline_next = now + 32'(saved);
          drift_next    = DRIFT_PERIOD;
          run_next      = 1'b1;
        end
      end
      CMD_STOP: begin
        if (run) begin
          if (lead[31] || lead == 32'd0) begin
            saved_next = 6'd1;
          end else if (lead > JIFFIES_PER_SEC) begin
            saved_next = SAVED_RESET;
          end else begin
            saved_next = lead[5:0];
          end
          run_next = 1'b0;
        end
      end
      default: begin
        run_next     = 1'b0;
        tmo_next     = 1'b0;
        elapsed_next = '0;
        saved_next   = SAVED_RESET;
        down_next    = limit != 19'd0;
        digits_next  = (limit != 19'd0) ? digits_limit : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      tmo      <= 1'b0;
      down     <= 1'b0;
      elapsed  <= '0;
      saved    <= SAVED_RESET;
      deadline <= '0;
      drift    <= DRIFT_PERIOD;
      digits   <= '0;
    end else if (fire) begin
      run      <= run_next;
      tmo      <= tmo_next;
      down     <= down_next;
      elapsed  <= elapsed_next;
      saved    <= saved_next;
      deadline <= deadline_next;
      drift    <= drift_next;
      digits   <= digits_next;
    end
  end

  assign res.passed    = passed;
  assign res.digits    = digits_next;
  assign res.timed_out = tmo_next;
  assign res.running   = run_next;

  `BHGC_ASSERT_IMPL(a_tmo_stopped, tmo, !run, "clock runs while timed out")
  `BHGC_ASSERT_IMPL(a_drift_range, 1'b1, drift != 5'd0 && drift <= DRIFT_PERIOD, "drift count out of range")
  `BHGC_ASSERT_IMPL(a_saved_range, 1'b1, saved != 6'd0 && saved <= SAVED_RESET, "saved jiffies out of range")
  `BHGC_ASSERT_IMPL(a_elapsed_sat, 1'b1, elapsed <= SECS_MAX, "elapsed seconds above saturation")

endmodule

/* src/bcd_hms_game_clock_core.sv */
// Game clock with BCD HH:MM:SS display driven by a 60 Hz time base.
// Input channel: in_valid/in_stall carry a command (func) and the current
// time-base value (now). Output channel: out_valid/out_stall carry one result
// per input transaction: the digits shown, second_passed, timed_out and
// is_running, all as they stand after that command.
// From input acceptance to out_valid a transaction passes one input register
// and one result register with the clock state updated in between. One
// transaction is accepted per cycle as long as the result register can drain.
// When the receiver stalls, the result register holds, the input register
// still takes one more transaction, and in_stall rises only once both are full.
// The user must write the count-down limit via cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce it. Its conversion to hours, minutes
// and seconds is registered behind the write and is ready before any following
// transaction reaches the state. A synchronous rst empties both registers and
// returns the clock to stopped, count-up, 00:00:00 with a zero limit.
`include "bcd_hms_game_clock_core_assert.svh"

module bcd_hms_game_clock_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [18:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        second_passed,
  output logic [3:0]  hour_tens,
  output logic [3:0]  hour_ones,
  output logic [2:0]  minute_tens,
  output logic [3:0]  minute_ones,
  output logic [2:0]  second_tens,
  output logic [3:0]  second_ones,
  output logic        timed_out,
  output logic        is_running
);
  import bhgc_pkg::*;

  logic        in_full;
  cmd_t        in_cmd;
  logic [31:0] in_now;
  logic        out_full;
  result_t     out_res;

  logic        advance;
  logic        take;
  logic [18:0] limit;
  hms_t        limit_hms;
  result_t     res;

  assign advance  = in_full && (!out_full || !out_stall);
  assign in_stall = in_full && !advance;
  assign take     = in_valid && !in_stall;

  bhgc_limit_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .limit     (limit),
    .limit_hms (limit_hms)
  );

  bhgc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .cmd       (in_cmd),
    .now       (in_now),
    .limit     (limit),
    .limit_hms (limit_hms),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_cmd <= cmd_t'(func);
      in_now <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign out_valid     = out_full;
  assign second_passed = out_res.passed;
  assign hour_tens     = out_res.digits[0];
  assign hour_ones     = out_res.digits[1];
  assign minute_tens   = out_res.digits[2][2:0];
  assign minute_ones   = out_res.digits[3];
  assign second_tens   = out_res.digits[4][2:0];
  assign second_ones   = out_res.digits[5];
  assign timed_out     = out_res.timed_out;
  assign is_running    = out_res.running;

  `BHGC_ASSERT_NEXT(a_adv_fills_out, advance, out_full, "result register empty after advance")
  `BHGC_ASSERT_IMPL(a_no_overwrite, out_full && out_stall, !advance, "stalled result overwritten")
  `BHGC_ASSERT_IMPL(a_pass_state, out_full && out_res.passed, out_res.running || out_res.timed_out, "second counted while stopped")

endmodule

/* tb/tb_bcd_hms_game_clock_core.sv */
`timescale 1ns / 100ps

module tb_bcd_hms_game_clock_core;
  import bhgc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    cmd_t        op;
    logic [31:0] t;
  } clock_cmd_t;

  typedef struct packed {
    logic       passed;
    logic [3:0] h_tens;
    logic [3:0] h_ones;
    logic [2:0] m_tens;
    logic [3:0] m_ones;
    logic [2:0] s_tens;
    logic [3:0] s_ones;
    logic       timed;
    logic       running;
  } readout_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [18:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_t        in_func = CMD_SAMPLE;
  logic [31:0] in_now = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        second_passed;
  logic [3:0]  hour_tens;
  logic [3:0]  hour_ones;
  logic [2:0]  minute_tens;
  logic [3:0]  minute_ones;
  logic [2:0]  second_tens;
  logic [3:0]  second_ones;
  logic        timed_out;
  logic        is_running;

  bcd_hms_game_clock_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (in_func),
    .now           (in_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .second_passed (second_passed),
    .hour_tens     (hour_tens),
    .hour_ones     (hour_ones),
    .minute_tens   (minute_tens),
    .minute_ones   (minute_ones),
    .second_tens   (second_tens),
    .second_ones   (second_ones),
    .timed_out     (timed_out),
    .is_running    (is_running)
  );

  // Predicted clock state.
  logic [18:0] limit_cfg = '0;
  logic        clk_running = 1'b0;
  logic        clk_timed = 1'b0;
  logic        count_down = 1'b0;
  logic [18:0] elapsed = '0;
  logic [5:0]  saved_jif = 6'd60;
  logic [31:0] deadline = '0;
  logic [4:0]  drift_left = 5'd20;
  logic [3:0]  shown [6] = '{default: 4'd0};

  clock_cmd_t  pending_cmds [$];
  readout_t    readouts [$];
  int          cmds_queued = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          gap_left = 0;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [3:0] digit_cap(input int pos);
    return (pos == 2 || pos == 4) ? 4'd5 : 4'd9;
  endfunction

  function automatic readout_t clock_step(input cmd_t op, input logic [31:0] t);
    readout_t    r;
    logic [31:0] diff;
    int unsigned v;
    int          i;
    logic        done;
    r = '0;
    case (op)
      CMD_SAMPLE: begin
        diff = t - deadline;
        if (clk_running && !clk_timed && !diff[31]) begin
          deadline = deadline + JIFFIES_PER_SEC;
          diff = t - deadline;
          // A time base that jumped past the next deadline resynchronizes.
          if (!diff[31]) begin
            deadline = t + JIFFIES_PER_SEC;
          end else begin
            drift_left = drift_left - 5'd1;
            if (drift_left == 5'd0) begin
              deadline = deadline + DRIFT_ADD;
              drift_left = DRIFT_PERIOD;
            end
          end
          if (elapsed < SECS_MAX) elapsed = elapsed + 19'd1;
          done = 1'b0;
          for (i = 5; i >= 0; i--) begin
            if (!done) begin
              if (!count_down) begin
                if (shown[i] < digit_cap(i)) begin
                  shown[i] = shown[i] + 4'd1;
                  done = 1'b1;
                end else begin
                  shown[i] = 4'd0;
                end
              end else begin
                if (shown[i] > 4'd0) begin
                  shown[i] = shown[i] - 4'd1;
                  done = 1'b1;
                end else begin
                  shown[i] = digit_cap(i);
                end
              end
            end
          end
          if (count_down && elapsed >= limit_cfg) begin
            clk_timed = 1'b1;
            clk_running = 1'b0;
          end
          r.passed = 1'b1;
        end
      end
      CMD_START: begin
        if (!clk_running && !clk_timed) begin
          deadline = t + 32'(saved_jif);
          drift_left = DRIFT_PERIOD;
          clk_running = 1'b1;
        end
      end
      CMD_STOP: begin
        if (clk_running) begin
          diff = deadline - t;
          if (diff[31] || diff == 32'd0) saved_jif = 6'd1;
          else if (diff > JIFFIES_PER_SEC) saved_jif = 6'(JIFFIES_PER_SEC);
          else saved_jif = diff[5:0];
          clk_running = 1'b0;
        end
      end
      default: begin
        clk_running = 1'b0;
        clk_timed = 1'b0;
        elapsed = '0;
        saved_jif = 6'(JIFFIES_PER_SEC);
        count_down = (limit_cfg != '0);
        v = count_down ? 32'(limit_cfg) : 0;
        shown[5] = 4'(v % 10); v = v / 10;
        shown[4] = 4'(v % 6);  v = v / 6;
        shown[3] = 4'(v % 10); v = v / 10;
        shown[2] = 4'(v % 6);  v = v / 6;
        shown[1] = 4'(v % 10); v = v / 10;
        shown[0] = 4'(v % 10);
      end
    endcase
    r.h_tens  = shown[0];
    r.h_ones  = shown[1];
    r.m_tens  = shown[2][2:0];
    r.m_ones  = shown[3];
    r.s_tens  = shown[4][2:0];
    r.s_ones  = shown[5];
    r.timed   = clk_timed;
    r.running = clk_running;
    return r;
  endfunction

  function automatic string readout_str(input readout_t r);
    return $sformatf("sec=%0d %0d%0d:%0d%0d:%0d%0d timed_out=%0d running=%0d",
                     r.passed, r.h_tens, r.h_ones, r.m_tens, r.m_ones,
                     r.s_tens, r.s_ones, r.timed, r.running);
  endfunction

  // Input driver: holds a transaction while stalled, idles in random bursts.
  always @(posedge clk) begin : drive_cmds
    clock_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
        gap_left = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        in_func <= nxt.op;
        in_now <= nxt.t;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted command and checks each accepted result.
  always @(posedge clk) begin : watch_results
    readout_t got;
    readout_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) readouts.push_back(clock_step(in_func, in_now));
      if (out_valid && !out_stall) begin
        results_seen = results_seen + 1;
        got = '{second_passed, hour_tens, hour_ones, minute_tens, minute_ones,
                second_tens, second_ones, timed_out, is_running};
        if (readouts.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected transaction: %s", readout_str(got));
        end else begin
          want = readouts.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch at cycle %0d\n  expected %s\n  actual   %s",
                       cycle_count, readout_str(want), readout_str(got));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic put(input cmd_t op, input logic [31:0] t);
    pending_cmds.push_back('{op, t});
    cmds_queued = cmds_queued + 1;
  endtask

  // Waits until every command has produced its result, then lets the pipe empty.
  task automatic settle();
    while (results_seen != cmds_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [18:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_cfg = v;
    // The block converts the limit to digits in the cycles behind the write.
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] tb_now;
    logic [18:0] lim;
    int          ph;
    int          k;
    int          r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 15;
    stall_pct = 15;

    // Count-up: commands while stopped, wrap of the time base, a deadline half
    // the range away, resync after a jump, and every clamp of the stop value.
    write_limit(19'd0);
    put(CMD_SAMPLE, 32'h0000_0000);
    put(CMD_STOP,   32'h0000_0005);
    put(CMD_START,  32'hFFFF_FFC0);
    put(CMD_SAMPLE, 32'hFFFF_FFFB);
    put(CMD_SAMPLE, 32'hFFFF_FFFC);
    put(CMD_START,  32'h0000_0001);
    put(CMD_SAMPLE, 32'h8000_0038);
    put(CMD_SAMPLE, 32'h0000_0100);
    put(CMD_STOP,   32'h0000_0141);
    put(CMD_STOP,   32'h0000_0150);
    put(CMD_START,  32'h0000_0200);
    put(CMD_STOP,   32'h0000_0201);
    put(CMD_START,  32'h0000_0300);
    put(CMD_STOP,   32'h0000_029C);
    put(CMD_START,  32'h0000_0400);
    put(CMD_STOP,   32'h0000_041E);
    put(CMD_START,  32'h0000_0500);
    put(CMD_SAMPLE, 32'h0000_051E);
    put(CMD_RESET,  32'h0000_0600);
    settle();

    // Count-down to time-out; the clock must not restart afterwards.
    write_limit(19'd2);
    put(CMD_RESET,  32'd0);
    put(CMD_START,  32'd1000);
    put(CMD_SAMPLE, 32'd1060);
    put(CMD_SAMPLE, 32'd1120);
    put(CMD_START,  32'd1200);
    put(CMD_SAMPLE, 32'd1300);
    put(CMD_STOP,   32'd1310);
    settle();

    // A limit past the largest count shows hours modulo 100 and wraps below zero.
    write_limit(19'd360001);
    put(CMD_RESET,  32'hFFFF_FFFF);
    put(CMD_START,  32'h7FFF_FFF0);
    put(CMD_SAMPLE, 32'h8000_002C);
    put(CMD_SAMPLE, 32'h8000_0068);
    settle();
    write_limit(19'h7FFFF);
    put(CMD_RESET,  32'h5555_AAAA);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: lim = 19'd0;
        1: lim = 19'($urandom_range(20, 60));
        2: lim = 19'($urandom_range(1, 3));
        3: lim = 19'($urandom_range(0, 19'h7FFFF));
        4: lim = SECS_MAX;
        default: lim = 19'($urandom_range(5, 30));
      endcase
      write_limit(lim);
      idle_pct = (ph == 5) ? 0 : ((ph % 2 == 0) ? 25 : 10);
      stall_pct = (ph == 5) ? 0 : ((ph == 1) ? 0 : 30);
      tb_now = $urandom();
      if (ph % 2 == 1) put(CMD_RESET, tb_now);
      for (k = 0; k < 150; k++) begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          tb_now = tb_now + $urandom_range(1, 40);
          put(CMD_SAMPLE, tb_now);
        end else if (r < 66) begin
          tb_now = tb_now + $urandom_range(41, 75);
          put(CMD_SAMPLE, tb_now);
        end else if (r < 74) begin
          tb_now = tb_now + $urandom_range(0, 20);
          put(CMD_START, tb_now);
        end else if (r < 81) begin
          tb_now = tb_now + $urandom_range(0, 20);
          put(CMD_STOP, tb_now);
        end else if (r < 84) begin
          put(CMD_RESET, $urandom());
        end else if (r < 89) begin
          tb_now = tb_now + $urandom_range(61, 200000);
          put(CMD_SAMPLE, tb_now);
        end else if (r < 93) begin
          // The time base steps backward.
          tb_now = tb_now - $urandom_range(1, 600);
          put(CMD_SAMPLE, tb_now);
        end else begin
          put(cmd_t'($urandom_range(0, 3)), $urandom());
        end
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && readouts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* bcd_hms_game_clock_core.f */
+incdir+src
src/bhgc_pkg.sv
src/bhgc_limit_conv.sv
src/bhgc_engine.sv
src/bcd_hms_game_clock_core.sv
tb/tb_bcd_hms_game_clock_core.sv
